// File: hdl/best_fit_block_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// Best-fit allocator assertion macros
// Concurrent check shorthands, clocked on clk_i, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// expression holds at every edge
`define BFA_ASSERT_NOW(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");

// consequent holds in the cycle after antecedent
`define BFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// Best-fit allocator package
// Sizes, codes and controller/datapath types.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

  localparam int unsigned MaxBlocks   = 64;
  localparam int unsigned HeapBytes   = 65536;
  localparam int unsigned HeaderBytes = 16;

  localparam int unsigned IdxW  = $clog2(MaxBlocks);
  localparam int unsigned CntW  = $clog2(MaxBlocks + 1);
  localparam int unsigned PosW  = $clog2(HeapBytes + 1);
  localparam int unsigned SizeW = 16;
  localparam int unsigned AddrW = 16;

  typedef enum logic {
    ReqAlloc = 1'b0,
    ReqFree  = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    RspOk      = 2'd0,
    RspNoSpace = 2'd1,
    RspBadFree = 2'd2
  } rsp_status_e;

  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic            iss_last;
    logic            out_busy;
    logic [CntW-1:0] cnt;
    logic [PosW-1:0] top;
  } stat_t;

endpackage

`default_nettype wire

// File: hdl/bfa_req_if.sv
// ----------------------------------------------------------------------------
// Best-fit allocator request channel
// Valid/ready channel carrying one allocate or free request.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfa_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] req_size;
  logic [15:0] block_addr;

  modport source (output valid, output req_type, output req_size, output block_addr,
                  input ready);
  modport sink (input valid, input req_type, input req_size, input block_addr,
                output ready);
endinterface

`default_nettype wire

// File: hdl/bfa_rsp_if.sv
// ----------------------------------------------------------------------------
// Best-fit allocator response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfa_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_addr;
  logic [1:0]  status;
  logic        reused;

  modport source (output valid, output result_addr, output status, output reused,
                  input ready);
  modport sink (input valid, input result_addr, input status, input reused,
                output ready);
endinterface

`default_nettype wire

// File: hdl/bfa_ctrl.sv
// ----------------------------------------------------------------------------
// Best-fit allocator controller
// Sequences request load, table walk and commit of one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_ctrl
  import bfa_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StFin  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StScan;
        end
      end
      StScan: begin
        if (stat_i.iss_last) begin
          state_d = StFin;
        end else begin
          cmd_o.issue = 1'b1;
        end
      end
      StFin: begin
        if (!stat_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/bfa_dp.sv
// ----------------------------------------------------------------------------
// Best-fit allocator datapath
// Block table memory, walk registers, best-fit tracking and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_dp
  import bfa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  logic              in_type_i,
  input  logic [SizeW-1:0]  in_size_i,
  input  logic [AddrW-1:0]  in_addr_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [AddrW-1:0]  out_addr_o,
  output logic [1:0]        out_status_o,
  output logic              out_reused_o
);

  // table entry: {in_use, size}
  logic [SizeW:0] mem [MaxBlocks];
  logic [SizeW:0] rd_q;

  req_type_e        type_q;
  logic [SizeW-1:0] size_q;
  logic [AddrW-1:0] addr_q;

  logic [CntW-1:0]  iss_q;
  logic             rd_vld_q;
  logic [IdxW-1:0]  rd_idx_q;
  logic [PosW-1:0]  pos_q;

  logic             found_q;
  logic [SizeW-1:0] best_size_q;
  logic [PosW-1:0]  best_pos_q;
  logic [IdxW-1:0]  best_idx_q;

  logic             hit_q;
  logic [SizeW-1:0] hit_size_q;
  logic [IdxW-1:0]  hit_idx_q;

  logic [CntW-1:0]  cnt_q;
  logic [PosW-1:0]  top_q;

  logic             out_valid_q;
  logic [AddrW-1:0] out_addr_q;
  rsp_status_e      out_status_q;
  logic             out_reused_q;

  logic [SizeW-1:0] rd_size;
  logic             rd_used;
  logic             fit;
  logic [PosW:0]    need_end;
  logic             no_space;
  logic             we;
  logic [IdxW-1:0]  widx;
  logic [SizeW:0]   wdata;

  assign rd_size  = rd_q[SizeW-1:0];
  assign rd_used  = rd_q[SizeW];
  assign fit      = !rd_used && (rd_size >= size_q) && (!found_q || best_size_q >= rd_size);
  assign need_end = {1'b0, top_q} + (PosW+1)'(HeaderBytes) + (PosW+1)'(size_q);
  assign no_space = (cnt_q >= CntW'(MaxBlocks)) || (need_end > (PosW+1)'(HeapBytes));

  always_comb begin
    we    = 1'b0;
    widx  = cnt_q[IdxW-1:0];
    wdata = {1'b1, size_q};
    if (cmd_i.commit) begin
      if (type_q == ReqAlloc) begin
        if (found_q) begin
          we    = 1'b1;
          widx  = best_idx_q;
          wdata = {1'b1, best_size_q};
        end else if (!no_space) begin
          we = 1'b1;
        end
      end else if (hit_q) begin
        we    = 1'b1;
        widx  = hit_idx_q;
        wdata = {1'b0, hit_size_q};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[widx] <= wdata;
    end
    if (cmd_i.issue) begin
      rd_q <= mem[iss_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      type_q <= req_type_e'(in_type_i);
      size_q <= in_size_i;
      addr_q <= in_addr_i;
    end
    if (cmd_i.issue) begin
      rd_idx_q <= iss_q[IdxW-1:0];
    end
    if (rd_vld_q && type_q == ReqAlloc && fit) begin
      best_size_q <= rd_size;
      best_pos_q  <= pos_q;
      best_idx_q  <= rd_idx_q;
    end
    if (rd_vld_q && type_q == ReqFree && !hit_q && pos_q == PosW'(addr_q)) begin
      hit_size_q <= rd_size;
      hit_idx_q  <= rd_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q    <= '0;
      rd_vld_q <= 1'b0;
      pos_q    <= '0;
      found_q  <= 1'b0;
      hit_q    <= 1'b0;
      cnt_q    <= '0;
      top_q    <= '0;
    end else begin
      rd_vld_q <= cmd_i.issue;
      if (cmd_i.load) begin
        iss_q   <= '0;
        pos_q   <= '0;
        found_q <= 1'b0;
        hit_q   <= 1'b0;
      end else begin
        if (cmd_i.issue) begin
          iss_q <= iss_q + 1'b1;
        end
        if (rd_vld_q) begin
          pos_q <= pos_q + PosW'(HeaderBytes) + PosW'(rd_size);
          if (type_q == ReqAlloc && fit) begin
            found_q <= 1'b1;
          end
          if (type_q == ReqFree && pos_q == PosW'(addr_q)) begin
            hit_q <= 1'b1;
          end
        end
      end
      if (cmd_i.commit && type_q == ReqAlloc && !found_q && !no_space) begin
        cnt_q <= cnt_q + 1'b1;
        top_q <= need_end[PosW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_addr_q   <= '0;
      out_status_q <= RspOk;
      out_reused_q <= 1'b0;
      if (type_q == ReqAlloc) begin
        if (found_q) begin
          out_addr_q   <= best_pos_q[AddrW-1:0];
          out_reused_q <= 1'b1;
        end else if (no_space) begin
          out_status_q <= RspNoSpace;
        end else begin
          out_addr_q <= top_q[AddrW-1:0];
        end
      end else if (hit_q) begin
        out_addr_q <= addr_q;
      end else begin
        out_status_q <= RspBadFree;
      end
    end
  end

  assign stat_o.iss_last = (iss_q == cnt_q);
  assign stat_o.out_busy = out_valid_q && !out_ready_i;
  assign stat_o.cnt      = cnt_q;
  assign stat_o.top      = top_q;

  assign out_valid_o  = out_valid_q;
  assign out_addr_o   = out_addr_q;
  assign out_status_o = out_status_q;
  assign out_reused_o = out_reused_q;

endmodule

`default_nettype wire

// File: hdl/best_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// Best-fit block allocator core
// Address-ordered block table with best-fit reuse and append at heap top.
// ----------------------------------------------------------------------------
//  channel  dir  payload                          handshake
//  req_i    in   req_type, req_size, block_addr   valid/ready
//  rsp_o    out  result_addr, status, reused      valid/ready
//
// One transaction at a time: a new request is accepted only once the last
// one has committed. The walk of the block table reads one entry per cycle.
// A finished result waits in an output register; commit stalls while it is
// still held by the sink. Reset clears block count, heap top, walk flags and
// output valid, but not the table; no clearing pass, table entries are
// written before they are read.
`default_nettype none

module best_fit_block_allocator_core
  import bfa_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  bfa_req_if.sink       req_i,
  bfa_rsp_if.source     rsp_o
);

  `include "best_fit_block_allocator_core_assert.svh"

  cmd_t  cmd;
  stat_t stat;

  bfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bfa_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_type_i    (req_i.req_type),
    .in_size_i    (req_i.req_size),
    .in_addr_i    (req_i.block_addr),
    .out_ready_i  (rsp_o.ready),
    .out_valid_o  (rsp_o.valid),
    .out_addr_o   (rsp_o.result_addr),
    .out_status_o (rsp_o.status),
    .out_reused_o (rsp_o.reused)
  );

  `BFA_ASSERT_NOW(a_cnt_max, stat.cnt <= CntW'(MaxBlocks))
  `BFA_ASSERT_NOW(a_top_max, stat.top <= PosW'(HeapBytes))
  `BFA_ASSERT_NOW(a_reuse_ok, !(rsp_o.valid && rsp_o.reused) || rsp_o.status == RspOk)
  `BFA_ASSERT_NEXT(a_commit_out, cmd.commit, rsp_o.valid)

endmodule

`default_nettype wire
